// ===== src/pfi_pkg.sv =====
// Package for the polyphase FIR interpolator: field widths, codes,
// request and control struct types. No dependencies.
`timescale 1ns / 1ps

package pfi_pkg;

  localparam int SampleBits     = 24;
  localparam int CoefBits       = 24;
  localparam int CoefFrac       = 22;
  localparam int PhaseBits      = 3;
  localparam int TapBits        = 4;
  localparam int ChanBits       = 1;
  localparam int FactorLog2Bits = 2;
  localparam int ChanCntBits    = 2;
  localparam int FacBits        = 4;
  localparam int CfgIdxBits     = 2;
  localparam int CfgDataBits    = 2;

  // action codes
  localparam logic ActSample = 1'b0;
  localparam logic ActCoef   = 1'b1;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgFactorLog2    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgChannelsInUse = 2'd1;

  localparam logic [FactorLog2Bits-1:0] FactorLog2Reset = 2'd2;
  localparam logic [ChanCntBits-1:0]    ChannelsReset   = 2'd1;

  typedef struct packed {
    logic                         action;
    logic [ChanBits-1:0]          channel;
    logic signed [SampleBits-1:0] sample_in;
    logic [PhaseBits-1:0]         coef_phase;
    logic [TapBits-1:0]           coef_tap;
    logic signed [CoefBits-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic [ChanBits-1:0]          out_channel;
    logic signed [SampleBits-1:0] sample_out;
    logic [PhaseBits-1:0]         phase;
    logic                         last;
  } out_item_t;

  // one multiply-accumulate step travelling down the datapath
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    logic                 tap_ok;
    logic [PhaseBits-1:0] phase;
    logic                 last_phase;
    logic [ChanBits-1:0]  channel;
  } pfi_ctl_t;

endpackage

// ===== src/polyphase_fir_interpolator.sv =====
// Multichannel polyphase FIR interpolator top level: configuration
// registers, tap history and coefficient RAMs, output register.
// Depends on pfi_pkg, pfi_ram, pfi_seq and pfi_mac.
//
// Usage:
//   Input requests arrive on in_valid_i/in_stall_o with an in_item_t payload.
//   A coefficient write (action = 1) fills one table entry.
//   A sample on an active channel with factor F > 1 produces F results on
//   out_valid_o/out_stall_i, phase 0 first, last set on the final one.
//   With factor 1 the sample comes back unchanged as a single result.
//   Samples on inactive channels are dropped without a result.
//   Each sample runs F x TAPS steps of the one shared multiplier, one tap per
//   cycle while the output is not held, and the block takes no new request
//   until those steps have drained from the MAC pipeline.
//   Registers are written through cfg_valid_i/cfg_ready_o (always ready):
//   index 0 is factor_log2, index 1 is channels_in_use; write only when idle.
//   Reset empties the histories (all taps read as zero), sets factor_log2
//   to 2 and channels_in_use to 1. The coefficient table is not cleared.
//   When the receiver stalls, the finished result holds in the output
//   register and the MAC pipeline freezes until it is taken.
`timescale 1ns / 1ps

module polyphase_fir_interpolator #(
  parameter int TAPS         = 16,
  parameter int MAX_CHANNELS = 2,
  parameter int MAX_FACTOR   = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pfi_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pfi_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfi_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [pfi_pkg::CfgDataBits-1:0]    cfg_data_i
);

  import pfi_pkg::*;

  localparam int HistDepth = MAX_CHANNELS * TAPS;
  localparam int CoefDepth = MAX_FACTOR * TAPS;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int CoefAw    = $clog2(CoefDepth);

  logic [FactorLog2Bits-1:0] factor_log2_q;
  logic [ChanCntBits-1:0]    channels_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic               out_free, hold, pipe_busy, res_valid, pass_valid, pass_taken;
  out_item_t          res_item, pass_item;
  pfi_ctl_t           ctl;
  logic               rd_en;
  logic               hist_we, coef_we;
  logic [HistAw-1:0]  hist_waddr, hist_raddr;
  logic [CoefAw-1:0]  coef_waddr, coef_raddr;
  logic [SampleBits-1:0] hist_wdata, hist_rdata;
  logic [CoefBits-1:0]   coef_wdata, coef_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_log2_q <= FactorLog2Reset;
      channels_q    <= ChannelsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFactorLog2:    factor_log2_q <= cfg_data_i;
        CfgChannelsInUse: channels_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign hold       = res_valid && !out_free;
  assign pass_taken = pass_valid && out_free;

  pfi_seq #(
    .TAPS        (TAPS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .factor_log2_i(factor_log2_q),
    .channels_i   (channels_q),
    .pipe_busy_i  (pipe_busy),
    .hold_i       (hold),
    .pass_taken_i (pass_taken),
    .pass_valid_o (pass_valid),
    .pass_item_o  (pass_item),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_wdata_o (hist_wdata),
    .hist_raddr_o (hist_raddr),
    .coef_we_o    (coef_we),
    .coef_waddr_o (coef_waddr),
    .coef_wdata_o (coef_wdata),
    .coef_raddr_o (coef_raddr),
    .rd_en_o      (rd_en),
    .ctl_o        (ctl)
  );

  pfi_ram #(
    .Width(SampleBits),
    .Depth(HistDepth)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .re_i   (rd_en),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  pfi_ram #(
    .Width(CoefBits),
    .Depth(CoefDepth)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_wdata),
    .re_i   (rd_en),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  pfi_mac #(
    .TAPS(TAPS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .hist_i     ($signed(hist_rdata)),
    .coef_i     ($signed(coef_rdata)),
    .hold_i     (hold),
    .busy_o     (pipe_busy),
    .res_valid_o(res_valid),
    .res_item_o (res_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid || pass_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && (res_valid || pass_valid)) begin
      out_q <= res_valid ? res_item : pass_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/pfi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfi_ram #(
  parameter int Width = 24,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/pfi_mac.sv =====
// Shared multiply-accumulate unit with round and saturate stage.
// Depends on pfi_pkg.
`timescale 1ns / 1ps

module pfi_mac #(
  parameter int TAPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pfi_pkg::pfi_ctl_t                    ctl_i,
  input  logic signed [pfi_pkg::SampleBits-1:0] hist_i,
  input  logic signed [pfi_pkg::CoefBits-1:0]  coef_i,
  input  logic                                 hold_i,
  output logic                                 busy_o,
  output logic                                 res_valid_o,
  output pfi_pkg::out_item_t                   res_item_o
);

  import pfi_pkg::*;

  localparam int ProdBits = SampleBits + CoefBits;
  localparam int AccBits  = ProdBits + $clog2(TAPS) + 1;
  localparam int QBits    = AccBits - CoefFrac;
  localparam logic signed [AccBits-1:0] RndHalf = AccBits'(2 ** (CoefFrac - 1));
  localparam logic signed [QBits-1:0]   SatHi   = QBits'(2 ** (SampleBits - 1) - 1);
  localparam logic signed [QBits-1:0]   SatLo   = -SatHi - QBits'(1);

  pfi_ctl_t ctl1_q, ctl2_q, done_ctl_q;
  logic     done_q;

  logic signed [ProdBits-1:0] mul;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [AccBits-1:0]  prod_ext;
  logic signed [AccBits-1:0]  acc_q;
  logic signed [AccBits-1:0]  rnd;
  logic signed [QBits-1:0]    quo;
  logic signed [SampleBits-1:0] sat;

  assign mul      = hist_i * coef_i;
  assign prod_ext = $signed({{(AccBits - ProdBits){prod_q[ProdBits-1]}}, prod_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else if (!hold_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid && ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold_i) begin
      // drop taps older than the history fill
      prod_q <= ctl1_q.tap_ok ? mul : '0;
      if (ctl2_q.valid) begin
        acc_q <= ctl2_q.first ? prod_ext : acc_q + prod_ext;
      end
      if (ctl2_q.valid && ctl2_q.last) begin
        done_ctl_q <= ctl2_q;
      end
    end
  end

  // round half up, then clamp to the sample range
  assign rnd = acc_q + RndHalf;
  assign quo = $signed(rnd[AccBits-1:CoefFrac]);

  always_comb begin
    priority if (quo > SatHi) begin
      sat = SatHi[SampleBits-1:0];
    end else if (quo < SatLo) begin
      sat = SatLo[SampleBits-1:0];
    end else begin
      sat = quo[SampleBits-1:0];
    end
  end

  assign busy_o      = ctl1_q.valid || ctl2_q.valid || done_q;
  assign res_valid_o = done_q;

  always_comb begin
    res_item_o.out_channel = done_ctl_q.channel;
    res_item_o.sample_out  = sat;
    res_item_o.phase       = done_ctl_q.phase;
    res_item_o.last        = done_ctl_q.last_phase;
  end

endmodule

// ===== src/pfi_seq.sv =====
// Sequencer: request decode, per-channel history pointers, table
// writes and the phase/tap counters that drive the shared MAC. Depends on pfi_pkg.
`timescale 1ns / 1ps

module pfi_seq #(
  parameter int TAPS         = 16,
  parameter int MAX_CHANNELS = 2,
  parameter int MAX_FACTOR   = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  input  pfi_pkg::in_item_t                          in_item_i,
  output logic                                       in_stall_o,
  input  logic [pfi_pkg::FactorLog2Bits-1:0]         factor_log2_i,
  input  logic [pfi_pkg::ChanCntBits-1:0]            channels_i,
  input  logic                                       pipe_busy_i,
  input  logic                                       hold_i,
  input  logic                                       pass_taken_i,
  output logic                                       pass_valid_o,
  output pfi_pkg::out_item_t                         pass_item_o,
  output logic                                       hist_we_o,
  output logic [$clog2(MAX_CHANNELS*TAPS)-1:0]       hist_waddr_o,
  output logic [pfi_pkg::SampleBits-1:0]             hist_wdata_o,
  output logic [$clog2(MAX_CHANNELS*TAPS)-1:0]       hist_raddr_o,
  output logic                                       coef_we_o,
  output logic [$clog2(MAX_FACTOR*TAPS)-1:0]         coef_waddr_o,
  output logic [pfi_pkg::CoefBits-1:0]               coef_wdata_o,
  output logic [$clog2(MAX_FACTOR*TAPS)-1:0]         coef_raddr_o,
  output logic                                       rd_en_o,
  output pfi_pkg::pfi_ctl_t                          ctl_o
);

  import pfi_pkg::*;

  localparam int HistAw = $clog2(MAX_CHANNELS * TAPS);
  localparam int CoefAw = $clog2(MAX_FACTOR * TAPS);
  localparam int TapAw  = $clog2(TAPS);
  localparam int TapCw  = $clog2(TAPS + 1);
  localparam int ChIdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StPass  = 2'd2;

  logic [1:0] state_q;

  logic [TapAw-1:0] ptr_q [MAX_CHANNELS];
  logic [TapCw-1:0] fill_q [MAX_CHANNELS];

  logic [TapAw-1:0]     t_q, idx_q, ptr0_q;
  logic [PhaseBits-1:0] p_q, pm1_q;
  logic [CoefAw-1:0]    caddr_q;
  logic [HistAw-1:0]    base_q;
  logic [TapCw-1:0]     cnt_q;
  logic [ChanBits-1:0]  chan_q;
  out_item_t            pass_q;

  logic              accept, is_coef, chan_ok, start, pass_start, step, t_last;
  logic [ChIdxW-1:0] ch_idx;
  logic [TapAw-1:0]  cur_ptr, nxt_ptr;
  logic [TapCw-1:0]  cur_cnt, nxt_cnt;
  logic [HistAw-1:0] base;
  logic [FacBits-1:0] fac_pow, fac;

  assign in_stall_o = !((state_q == StIdle) && !pipe_busy_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_coef    = (in_item_i.action == ActCoef);

  // active count is the register clamped to 1..MAX_CHANNELS
  assign chan_ok = (32'(in_item_i.channel) < MAX_CHANNELS) &&
                   ((32'(in_item_i.channel) < 32'(channels_i)) || (in_item_i.channel == '0));

  assign ch_idx  = ChIdxW'(in_item_i.channel);
  assign cur_ptr = ptr_q[ch_idx];
  assign cur_cnt = fill_q[ch_idx];
  assign nxt_ptr = (32'(cur_ptr) == TAPS - 1) ? '0 : cur_ptr + TapAw'(1);
  assign nxt_cnt = (32'(cur_cnt) == TAPS) ? cur_cnt : cur_cnt + TapCw'(1);
  assign base    = HistAw'(32'(in_item_i.channel) * TAPS);

  assign fac_pow = FacBits'(1) << factor_log2_i;
  assign fac     = (32'(fac_pow) > MAX_FACTOR) ? FacBits'(MAX_FACTOR) : fac_pow;

  assign start      = accept && !is_coef && chan_ok && (factor_log2_i != '0);
  assign pass_start = accept && !is_coef && chan_ok && (factor_log2_i == '0);

  assign hist_we_o    = start;
  assign hist_waddr_o = base + HistAw'(nxt_ptr);
  assign hist_wdata_o = in_item_i.sample_in;

  assign coef_we_o    = accept && is_coef &&
                        (32'(in_item_i.coef_phase) < MAX_FACTOR) &&
                        (32'(in_item_i.coef_tap) < TAPS);
  assign coef_waddr_o = CoefAw'(32'(in_item_i.coef_phase) * TAPS + 32'(in_item_i.coef_tap));
  assign coef_wdata_o = in_item_i.coef_value;

  assign rd_en_o      = (state_q == StIssue) && !hold_i;
  assign step         = rd_en_o;
  assign t_last       = (32'(t_q) == TAPS - 1);
  assign hist_raddr_o = base_q + HistAw'(idx_q);
  assign coef_raddr_o = caddr_q;

  always_comb begin
    ctl_o.valid      = (state_q == StIssue);
    ctl_o.first      = (t_q == '0);
    ctl_o.last       = t_last;
    ctl_o.tap_ok     = (32'(t_q) < 32'(cnt_q));
    ctl_o.phase      = p_q;
    ctl_o.last_phase = (p_q == pm1_q);
    ctl_o.channel    = chan_q;
  end

  assign pass_valid_o = (state_q == StPass);
  assign pass_item_o  = pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        ptr_q[i]  <= '0;
        fill_q[i] <= '0;
      end
      t_q     <= '0;
      idx_q   <= '0;
      p_q     <= '0;
      caddr_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start) begin
            ptr_q[ch_idx]  <= nxt_ptr;
            fill_q[ch_idx] <= nxt_cnt;
            t_q            <= '0;
            idx_q          <= nxt_ptr;
            p_q            <= '0;
            caddr_q        <= '0;
            state_q        <= StIssue;
          end else if (pass_start) begin
            state_q <= StPass;
          end
        end
        StIssue: begin
          if (step) begin
            caddr_q <= caddr_q + CoefAw'(1);
            if (t_last) begin
              // rewind to the newest tap for the next phase
              t_q   <= '0;
              idx_q <= ptr0_q;
              p_q   <= p_q + PhaseBits'(1);
              if (p_q == pm1_q) begin
                state_q <= StIdle;
              end
            end else begin
              t_q   <= t_q + TapAw'(1);
              idx_q <= (idx_q == '0) ? TapAw'(TAPS - 1) : idx_q - TapAw'(1);
            end
          end
        end
        StPass: begin
          if (pass_taken_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      ptr0_q <= nxt_ptr;
      cnt_q  <= nxt_cnt;
      base_q <= base;
      chan_q <= in_item_i.channel;
      pm1_q  <= PhaseBits'(fac - FacBits'(1));
    end
    if (pass_start) begin
      pass_q.out_channel <= in_item_i.channel;
      pass_q.sample_out  <= in_item_i.sample_in;
      pass_q.phase       <= '0;
      pass_q.last        <= 1'b1;
    end
  end

endmodule

// ===== tb/sv/polyphase_fir_interpolator_test.sv =====
// Self-checking testbench for polyphase_fir_interpolator: in-order predictor of the
// polyphase dot products, randomized idle/stall traffic, register sweeps and hold-off.
// Depends on pfi_pkg and the polyphase_fir_interpolator RTL.
`timescale 1ns / 1ps

module polyphase_fir_interpolator_test;
  import pfi_pkg::*;

  localparam int Taps         = 16;
  localparam int MaxChannels  = 2;
  localparam int MaxFactor    = 8;
  localparam int TableDepth   = MaxFactor * Taps;
  localparam int SettleCycles = MaxFactor * Taps + 20;
  localparam int QuietLimit   = 20000;
  localparam int HoldOffCycles = 900;
  localparam int MaxReported  = 10;

  localparam logic [CfgIdxBits-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgSpareB = 2'd3;

  localparam logic signed [SampleBits-1:0] MaxWord = 24'sh7fffff;
  localparam logic signed [SampleBits-1:0] MinWord = 24'sh800000;
  localparam longint SatHi = (longint'(1) <<< (SampleBits - 1)) - 1;
  localparam longint SatLo = -SatHi - 1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  polyphase_fir_interpolator #(
    .TAPS        (Taps),
    .MAX_CHANNELS(MaxChannels),
    .MAX_FACTOR  (MaxFactor)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic signed [SampleBits-1:0] tap_hist [MaxChannels][Taps];
  logic signed [CoefBits-1:0]   coef_tab [TableDepth];
  logic [FactorLog2Bits-1:0]    cur_factor_log2;
  logic [ChanCntBits-1:0]       cur_chans;
  out_item_t                    pending_outputs[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_left      = 0;
  int  quiet_cycles   = 0;
  int  n_requests     = 0;
  int  n_results      = 0;
  int  n_cfg_writes   = 0;
  int  n_mismatches   = 0;
  bit  busy_since_idle = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [SampleBits-1:0] round_to_sample(longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (CoefFrac - 1))) >>> CoefFrac;
    if (q > SatHi) q = SatHi;
    else if (q < SatLo) q = SatLo;
    return q[SampleBits-1:0];
  endfunction

  // Apply one accepted request to the predictor and queue the outputs it causes.
  function automatic void predict_outputs(in_item_t it);
    int        active;
    int        factor;
    int        ch;
    longint    acc;
    out_item_t r;
    if (it.action == ActCoef) begin
      coef_tab[it.coef_phase * Taps + it.coef_tap] = it.coef_value;
      return;
    end
    active = (cur_chans == 0) ? 1 : (cur_chans > MaxChannels) ? MaxChannels : cur_chans;
    ch = int'(it.channel);
    if (ch >= active) return;
    factor = 1 << cur_factor_log2;
    if (factor > MaxFactor) factor = MaxFactor;
    if (factor == 1) begin
      r.out_channel = it.channel;
      r.sample_out  = it.sample_in;
      r.phase       = '0;
      r.last        = 1'b1;
      pending_outputs.push_back(r);
      return;
    end
    for (int t = Taps - 1; t > 0; t--) tap_hist[ch][t] = tap_hist[ch][t-1];
    tap_hist[ch][0] = it.sample_in;
    for (int p = 0; p < factor; p++) begin
      acc = 0;
      for (int t = 0; t < Taps; t++)
        acc += longint'(coef_tab[p * Taps + t]) * longint'(tap_hist[ch][t]);
      r.out_channel = it.channel;
      r.sample_out  = round_to_sample(acc);
      r.phase       = PhaseBits'(p);
      r.last        = (p == factor - 1);
      pending_outputs.push_back(r);
    end
  endfunction

  function automatic logic signed [SampleBits-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return MaxWord;
      1:       return MinWord;
      2, 3, 4: return SampleBits'($urandom_range(0, 8191) - 4096);
      default: return SampleBits'($urandom());
    endcase
  endfunction

  function automatic in_item_t make_sample(logic ch, logic signed [SampleBits-1:0] s);
    in_item_t it;
    it.action     = ActSample;
    it.channel    = ch;
    it.sample_in  = s;
    it.coef_phase = PhaseBits'($urandom());
    it.coef_tap   = TapBits'($urandom());
    it.coef_value = CoefBits'($urandom());
    return it;
  endfunction

  function automatic in_item_t make_coef(int idx, logic signed [CoefBits-1:0] v);
    in_item_t it;
    it.action     = ActCoef;
    it.channel    = ChanBits'($urandom());
    it.sample_in  = SampleBits'($urandom());
    it.coef_phase = PhaseBits'(idx / Taps);
    it.coef_tap   = TapBits'(idx % Taps);
    it.coef_value = v;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_outputs(it);
    n_requests++;
    busy_since_idle = 1;
  endtask

  task automatic send_random_item();
    if ($urandom_range(0, 9) == 0)
      send_item(make_coef($urandom_range(0, TableDepth - 1), rand_word()));
    else
      send_item(make_sample(ChanBits'($urandom()), rand_word()));
  endtask

  // Drop valid, wait for every expected output, then let dropped work finish.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
    if (busy_since_idle) repeat (SettleCycles) @(negedge clk_i);
    busy_since_idle = 0;
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFactorLog2:    cur_factor_log2 = val;
      CfgChannelsInUse: cur_chans       = val;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_kernel();
    for (int i = 0; i < TableDepth; i++) send_item(make_coef(i, rand_word()));
  endtask

  task automatic test_reset_defaults();
    load_kernel();
    send_item(make_sample(1'b0, MaxWord));
    send_item(make_sample(1'b0, MinWord));
    send_item(make_sample(1'b0, '0));
    send_item(make_sample(1'b0, rand_word()));
    // channel 1 is inactive after reset
    send_item(make_sample(1'b1, rand_word()));
  endtask

  task automatic test_passthrough();
    write_reg(CfgFactorLog2, 2'd0);
    write_reg(CfgChannelsInUse, 2'd2);
    send_item(make_sample(1'b0, MaxWord));
    send_item(make_sample(1'b1, MinWord));
    send_item(make_sample(1'b1, '0));
    send_item(make_sample(1'b0, -24'sd1));
  endtask

  task automatic test_channel_count();
    // zero active channels acts as one
    write_reg(CfgChannelsInUse, 2'd0);
    write_reg(CfgFactorLog2, 2'd1);
    send_item(make_sample(1'b1, rand_word()));
    send_item(make_sample(1'b0, MaxWord));
    // three clamps to two
    write_reg(CfgChannelsInUse, 2'd3);
    send_item(make_sample(1'b1, MinWord));
    send_item(make_sample(1'b0, rand_word()));
    // unused register indexes must not disturb the setting
    write_reg(CfgSpareA, CfgDataBits'($urandom()));
    write_reg(CfgSpareB, CfgDataBits'($urandom()));
    send_item(make_sample(1'b1, rand_word()));
  endtask

  task automatic test_saturation();
    write_reg(CfgFactorLog2, 2'd3);
    write_reg(CfgChannelsInUse, 2'd2);
    // branch 0 at full positive gain, branch 1 at full negative gain
    for (int t = 0; t < Taps; t++) send_item(make_coef(t, MaxWord));
    for (int t = 0; t < Taps; t++) send_item(make_coef(Taps + t, MinWord));
    repeat (5) send_item(make_sample(1'b1, MaxWord));
    repeat (3) send_item(make_sample(1'b0, MinWord));
  endtask

  task automatic test_random_traffic();
    logic [FactorLog2Bits-1:0] fl;
    // replace the extreme gains of branches 0 and 1
    for (int i = 0; i < 2 * Taps; i++) send_item(make_coef(i, rand_word()));
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int f = 0; f < 4; f++) begin
        fl = FactorLog2Bits'((f + mode) % 4);
        write_reg(CfgFactorLog2, fl);
        write_reg(CfgChannelsInUse, CfgDataBits'($urandom_range(0, 3)));
        repeat (9) send_random_item();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_hold_off();
    write_reg(CfgFactorLog2, 2'd3);
    write_reg(CfgChannelsInUse, 2'd2);
    // hold the output while requests keep coming, so the input stalls
    hold_left = HoldOffCycles;
    repeat (10) send_random_item();
  endtask

  task automatic test_sender_pause();
    write_reg(CfgFactorLog2, 2'd1);
    recv_stall_pct = 47;
    repeat (6) send_random_item();
    wait_idle();
    repeat (6) send_random_item();
    recv_stall_pct = 0;
  endtask

  // output side: random stall plus an explicit hold-off stretch
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic note_mismatch(string what, out_item_t exp, out_item_t got);
    n_mismatches++;
    if (n_mismatches <= MaxReported) begin
      $display("%0t: %s: expected ch=%0d sample=%0d phase=%0d last=%0d", $time, what,
               exp.out_channel, exp.sample_out, exp.phase, exp.last);
      $display("%0t: %s: got      ch=%0d sample=%0d phase=%0d last=%0d", $time, what,
               got.out_channel, got.sample_out, got.phase, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_outputs.size() == 0) begin
        note_mismatch("output with none pending", '0, out_item_o);
      end else begin
        exp = pending_outputs.pop_front();
        if (out_item_o.out_channel !== exp.out_channel || out_item_o.sample_out !== exp.sample_out
            || out_item_o.phase !== exp.phase || out_item_o.last !== exp.last)
          note_mismatch("output mismatch", exp, out_item_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no request moved for %0d cycles", QuietLimit);
      $display("polyphase_fir_interpolator_test failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    cur_factor_log2 = FactorLog2Reset;
    cur_chans       = ChannelsReset;
    foreach (tap_hist[c, t]) tap_hist[c][t] = '0;
    foreach (coef_tab[i]) coef_tab[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_passthrough();
    test_channel_count();
    test_saturation();
    test_random_traffic();
    test_output_hold_off();
    test_sender_pause();
    wait_idle();

    n_mismatches += pending_outputs.size();
    $display("covered %0d requests and %0d register writes, %0d outputs checked", n_requests,
             n_cfg_writes, n_results);
    $display("factors 1x to 8x, channel counts 0 to 3, idle/stall mixes, output hold-off");
    if (n_mismatches == 0) begin
      $display("polyphase_fir_interpolator_test passed");
    end else begin
      $display("%0d mismatches", n_mismatches);
      $display("polyphase_fir_interpolator_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pfi_pkg.sv
src/pfi_ram.sv
src/pfi_mac.sv
src/pfi_seq.sv
src/polyphase_fir_interpolator.sv
tb/sv/polyphase_fir_interpolator_test.sv
